[rtl/piu_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// piu_pkg
// Shared types, constants and tables for the packed index unpacker.
// ----------------------------------------------------------------------------
package piu_pkg;

    localparam int WORD_BITS   = 64;
    localparam int INDEX_BITS  = 12;
    localparam int MAX_ENTRIES = 4096;
    localparam int CNT_BITS    = $clog2(MAX_ENTRIES) + 1;
    localparam int SIZE_BITS   = INDEX_BITS + 1;
    localparam int W_BITS      = 4;
    localparam int FIELD_BITS  = 16;
    localparam int REM_BITS    = $clog2(WORD_BITS) + 1;
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 13;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH) + 1;

    localparam logic [SIZE_BITS-1:0] SIZE_CAP  = SIZE_BITS'(1 << INDEX_BITS);
    localparam logic [CNT_BITS-1:0]  TOTAL_CAP = CNT_BITS'(MAX_ENTRIES);

    localparam logic [CFG_IDX_BITS-1:0] CFG_PALETTE_SIZE = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH_FLOOR  = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_ENTRY_TOTAL  = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLAMP_MODE   = CFG_IDX_BITS'(3);

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [W_BITS-1:0]    width;
        logic [REM_BITS-1:0]  fields;
        logic [SIZE_BITS-1:0] size;
        logic [CNT_BITS-1:0]  total;
        logic                 clamp;
    } piu_job_t;

    // floor(64 / w) for the field widths the block can produce
    function automatic logic [REM_BITS-1:0] fields_per_word(input logic [W_BITS-1:0] w);
        logic [REM_BITS-1:0] n;
        case (w)
            4'd1:    n = REM_BITS'(64);
            4'd2:    n = REM_BITS'(32);
            4'd3:    n = REM_BITS'(21);
            4'd4:    n = REM_BITS'(16);
            4'd5:    n = REM_BITS'(12);
            4'd6:    n = REM_BITS'(10);
            4'd7:    n = REM_BITS'(9);
            4'd8:    n = REM_BITS'(8);
            4'd9:    n = REM_BITS'(7);
            4'd10:   n = REM_BITS'(6);
            4'd11:   n = REM_BITS'(5);
            4'd12:   n = REM_BITS'(5);
            4'd13:   n = REM_BITS'(4);
            4'd14:   n = REM_BITS'(4);
            4'd15:   n = REM_BITS'(4);
            default: n = REM_BITS'(64);
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

[rtl/packed_index_unpacker_core.sv]
// The word is written into the queue, then loaded into the engine registers,
// and each index is registered in the output register. One index per cycle
// unless m_ready stalls; the next word loads only once the last field is out.
// A two-entry queue lets intake run ahead of the engine.
// Reset: registers return to defaults, entry count and halt flag clear,
// queue and output register empty.
`default_nettype none
// ----------------------------------------------------------------------------
// packed_index_unpacker_core
// Unpacks fixed-width palette indices from 64-bit packed words.
// ----------------------------------------------------------------------------
module packed_index_unpacker_core import piu_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_wr_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wr_data,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [WORD_BITS-1:0]     s_packed_word,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [INDEX_BITS-1:0]         m_index_value,
    output logic                          m_range_error,
    output logic                          m_last_of_word,
    output logic                          m_array_done
);

    logic     q_wr_valid, q_wr_ready;
    piu_job_t q_wr_data;
    logic     q_rd_valid, q_rd_ready;
    piu_job_t q_rd_data;

    piu_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_packed_word (s_packed_word),
        .q_wr_valid    (q_wr_valid),
        .q_wr_ready    (q_wr_ready),
        .q_wr_data     (q_wr_data)
    );

    piu_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    piu_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_rd_valid     (q_rd_valid),
        .q_rd_ready     (q_rd_ready),
        .q_rd_data      (q_rd_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_index_value  (m_index_value),
        .m_range_error  (m_range_error),
        .m_last_of_word (m_last_of_word),
        .m_array_done   (m_array_done)
    );

endmodule
`default_nettype wire

[rtl/piu_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// piu_front
// Configuration registers and item intake: derives field width, field
// count and saturated limits for each accepted word.
// ----------------------------------------------------------------------------
module piu_front import piu_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_wr_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wr_data,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [WORD_BITS-1:0]     s_packed_word,
    output logic                          q_wr_valid,
    input  wire logic                     q_wr_ready,
    output piu_job_t                      q_wr_data
);

    logic [SIZE_BITS-1:0]  palette_size_reg, palette_size_next;
    logic [W_BITS-1:0]     width_floor_reg, width_floor_next;
    logic [CNT_BITS-1:0]   entry_total_reg, entry_total_next;
    logic                  clamp_mode_reg, clamp_mode_next;

    logic [SIZE_BITS-1:0]  size_sat;
    logic [INDEX_BITS-1:0] size_m1;
    logic [W_BITS-1:0]     bw;
    logic [W_BITS-1:0]     width;
    logic [CNT_BITS-1:0]   total_sat;

    always_comb begin
        palette_size_next = palette_size_reg;
        width_floor_next  = width_floor_reg;
        entry_total_next  = entry_total_reg;
        clamp_mode_next   = clamp_mode_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_PALETTE_SIZE: palette_size_next = cfg_wr_data[SIZE_BITS-1:0];
                CFG_WIDTH_FLOOR:  width_floor_next  = cfg_wr_data[W_BITS-1:0];
                CFG_ENTRY_TOTAL:  entry_total_next  = cfg_wr_data[CNT_BITS-1:0];
                CFG_CLAMP_MODE:   clamp_mode_next   = cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            palette_size_reg <= SIZE_BITS'(16);
            width_floor_reg  <= W_BITS'(4);
            entry_total_reg  <= TOTAL_CAP;
            clamp_mode_reg   <= 1'b1;
        end else begin
            palette_size_reg <= palette_size_next;
            width_floor_reg  <= width_floor_next;
            entry_total_reg  <= entry_total_next;
            clamp_mode_reg   <= clamp_mode_next;
        end
    end

    always_comb begin
        if (palette_size_reg == '0) begin
            size_sat = SIZE_BITS'(1);
        end else if (palette_size_reg > SIZE_CAP) begin
            size_sat = SIZE_CAP;
        end else begin
            size_sat = palette_size_reg;
        end
        size_m1 = INDEX_BITS'(size_sat - SIZE_BITS'(1));

        bw = '0;
        for (int i = 0; i < INDEX_BITS; i++) begin
            if (size_m1[i]) begin
                bw = W_BITS'(i + 1);
            end
        end
        width = (bw < width_floor_reg) ? width_floor_reg : bw;
        if (width == '0) begin
            width = W_BITS'(1);
        end

        if (entry_total_reg == '0 || entry_total_reg > TOTAL_CAP) begin
            total_sat = TOTAL_CAP;
        end else begin
            total_sat = entry_total_reg;
        end
    end

    assign s_ready    = q_wr_ready;
    assign q_wr_valid = s_valid;

    always_comb begin
        q_wr_data.word   = s_packed_word;
        q_wr_data.width  = width;
        q_wr_data.fields = fields_per_word(width);
        q_wr_data.size   = size_sat;
        q_wr_data.total  = total_sat;
        q_wr_data.clamp  = clamp_mode_reg;
    end

endmodule
`default_nettype wire

[rtl/piu_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// piu_queue
// Two-entry job queue between the intake and the unpack engine.
// ----------------------------------------------------------------------------
module piu_queue import piu_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     wr_valid,
    output logic          wr_ready,
    input  wire piu_job_t wr_data,
    output logic          rd_valid,
    input  wire logic     rd_ready,
    output piu_job_t      rd_data
);

    piu_job_t                mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]    count_reg, count_next;
    logic                    push, pop;

    assign wr_ready = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = push ? QPTR_BITS'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? QPTR_BITS'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = QCNT_BITS'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = QCNT_BITS'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue count overflow");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == QCNT_BITS'($past(count_reg) + 1'b1))
        else $error("queue count did not follow push");

    a_count_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !push |=> count_reg == QCNT_BITS'($past(count_reg) - 1'b1))
        else $error("queue count did not follow pop");

endmodule
`default_nettype wire

[rtl/piu_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// piu_back
// Unpack engine: shifts one field out of the current word per cycle unless
// m_ready stalls; range-checks, counts array entries, drives output register.
// ----------------------------------------------------------------------------
module piu_back import piu_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   q_rd_valid,
    output logic                        q_rd_ready,
    input  wire piu_job_t               q_rd_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [INDEX_BITS-1:0]       m_index_value,
    output logic                        m_range_error,
    output logic                        m_last_of_word,
    output logic                        m_array_done
);

    logic                  active_reg, active_next;
    logic                  halted_reg, halted_next;
    logic [WORD_BITS-1:0]  word_reg, word_next;
    logic [W_BITS-1:0]     width_reg, width_next;
    logic [REM_BITS-1:0]   rem_reg, rem_next;
    logic [SIZE_BITS-1:0]  size_reg, size_next;
    logic [CNT_BITS-1:0]   total_reg, total_next;
    logic                  clamp_reg, clamp_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;

    logic                  m_valid_reg, m_valid_next;
    logic [INDEX_BITS-1:0] m_index_reg, m_index_next;
    logic                  m_err_reg, m_err_next;
    logic                  m_last_reg, m_last_next;
    logic                  m_done_reg, m_done_next;

    logic                  fire;
    logic                  pop;
    logic [FIELD_BITS-1:0] field;
    logic [FIELD_BITS-1:0] size_ext;
    logic                  out_of_range;
    logic                  err;
    logic [SIZE_BITS-1:0]  size_m1;
    logic [CNT_BITS-1:0]   cnt_inc;
    logic                  done;
    logic                  last;

    assign fire       = active_reg && (!m_valid_reg || m_ready);
    assign pop        = !active_reg && q_rd_valid;
    assign q_rd_ready = !active_reg;

    always_comb begin
        field        = word_reg[FIELD_BITS-1:0] & ~({FIELD_BITS{1'b1}} << width_reg);
        size_ext     = FIELD_BITS'(size_reg);
        out_of_range = (field >= size_ext);
        err          = out_of_range && !clamp_reg;
        size_m1      = SIZE_BITS'(size_reg - SIZE_BITS'(1));
        cnt_inc      = CNT_BITS'(cnt_reg + 1'b1);
        done         = (cnt_inc >= total_reg);
        last         = (rem_reg == REM_BITS'(1)) || done;
    end

    always_comb begin
        active_next  = active_reg;
        halted_next  = halted_reg;
        word_next    = word_reg;
        width_next   = width_reg;
        rem_next     = rem_reg;
        size_next    = size_reg;
        total_next   = total_reg;
        clamp_next   = clamp_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_index_next = m_index_reg;
        m_err_next   = m_err_reg;
        m_last_next  = m_last_reg;
        m_done_next  = m_done_reg;

        if (pop && !halted_reg) begin
            active_next = 1'b1;
            word_next   = q_rd_data.word;
            width_next  = q_rd_data.width;
            rem_next    = q_rd_data.fields;
            size_next   = q_rd_data.size;
            total_next  = q_rd_data.total;
            clamp_next  = q_rd_data.clamp;
        end

        if (fire) begin
            m_valid_next = 1'b1;
            if (err) begin
                m_index_next = '0;
                m_err_next   = 1'b1;
                m_last_next  = 1'b1;
                m_done_next  = 1'b0;
                halted_next  = 1'b1;
                active_next  = 1'b0;
            end else begin
                m_index_next = out_of_range ? size_m1[INDEX_BITS-1:0]
                                            : field[INDEX_BITS-1:0];
                m_err_next   = 1'b0;
                m_last_next  = last;
                m_done_next  = done;
                cnt_next     = done ? '0 : cnt_inc;
                if (last) begin
                    active_next = 1'b0;
                end else begin
                    word_next = word_reg >> width_reg;
                    rem_next  = REM_BITS'(rem_reg - 1'b1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            halted_reg  <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            halted_reg  <= halted_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        word_reg    <= word_next;
        width_reg   <= width_next;
        rem_reg     <= rem_next;
        size_reg    <= size_next;
        total_reg   <= total_next;
        clamp_reg   <= clamp_next;
        m_index_reg <= m_index_next;
        m_err_reg   <= m_err_next;
        m_last_reg  <= m_last_next;
        m_done_reg  <= m_done_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_index_value  = m_index_reg;
    assign m_range_error  = m_err_reg;
    assign m_last_of_word = m_last_reg;
    assign m_array_done   = m_done_reg;

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared without reset");

    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> !active_reg)
        else $error("engine active after halt");

    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_err_reg |-> m_last_reg && !m_done_reg && m_index_reg == '0)
        else $error("malformed error item");

    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_done_reg |-> m_last_reg)
        else $error("array end without end of word");

    a_rem_live: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> rem_reg != '0)
        else $error("engine active with no fields left");

endmodule
`default_nettype wire
